// ===== rtl/sbh_pkg.sv =====
// shared types, constants and bound tables for the saturating bucket histogram
// used by sbh_interval and saturating_bucket_histogram; no dependencies
`default_nettype none

package sbh_pkg;

    localparam int MAX_BUCKETS = 14;
    localparam int BKT_AW      = (MAX_BUCKETS > 2) ? $clog2(MAX_BUCKETS) : 1;

    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 328;

    localparam logic [1:0] KIND_DUR  = 2'd0;
    localparam logic [1:0] KIND_SIZE = 2'd1;
    localparam logic [1:0] KIND_TTL  = 2'd2;

    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    // floor(x / 1000) = floor((x >> 3) * RECIP >> 34) for x below 2^30
    localparam logic [27:0] DIV1000_RECIP = 28'd137438954;

    localparam int NB_DUR_I  = (MAX_BUCKETS - 1 < 13) ? MAX_BUCKETS - 1 : 13;
    localparam int NB_SIZE_I = (MAX_BUCKETS - 1 < 9)  ? MAX_BUCKETS - 1 : 9;
    localparam int NB_TTL_I  = (MAX_BUCKETS - 1 < 12) ? MAX_BUCKETS - 1 : 12;

    typedef struct packed {
        logic        valid;
        logic        rej;
        logic [63:0] bsamp;
        logic [63:0] ssamp;
    } sbh_iv_t;

    function automatic logic [3:0] sbh_nbounds(input logic [1:0] kind);
        logic [3:0] n;
        case (kind)
            KIND_DUR:  n = 4'(NB_DUR_I);
            KIND_SIZE: n = 4'(NB_SIZE_I);
            default:   n = 4'(NB_TTL_I);
        endcase
        return n;
    endfunction

    function automatic logic [63:0] sbh_bound(input logic [1:0] kind, input logic [3:0] idx);
        logic [63:0] b;
        b = '0;
        case (kind)
            KIND_DUR: begin
                case (idx)
                    4'd0:    b = 64'd1000000;
                    4'd1:    b = 64'd5000000;
                    4'd2:    b = 64'd10000000;
                    4'd3:    b = 64'd25000000;
                    4'd4:    b = 64'd50000000;
                    4'd5:    b = 64'd100000000;
                    4'd6:    b = 64'd250000000;
                    4'd7:    b = 64'd500000000;
                    4'd8:    b = 64'd1000000000;
                    4'd9:    b = 64'd2000000000;
                    4'd10:   b = 64'd5000000000;
                    4'd11:   b = 64'd10000000000;
                    4'd12:   b = 64'd30000000000;
                    default: b = '0;
                endcase
            end
            KIND_SIZE: begin
                case (idx)
                    4'd0:    b = 64'd0;
                    4'd1:    b = 64'd64;
                    4'd2:    b = 64'd256;
                    4'd3:    b = 64'd1024;
                    4'd4:    b = 64'd4096;
                    4'd5:    b = 64'd16384;
                    4'd6:    b = 64'd65536;
                    4'd7:    b = 64'd262144;
                    4'd8:    b = 64'd1048576;
                    default: b = '0;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    b = 64'd0;
                    4'd1:    b = 64'd1;
                    4'd2:    b = 64'd5;
                    4'd3:    b = 64'd30;
                    4'd4:    b = 64'd60;
                    4'd5:    b = 64'd300;
                    4'd6:    b = 64'd1800;
                    4'd7:    b = 64'd3600;
                    4'd8:    b = 64'd21600;
                    4'd9:    b = 64'd86400;
                    4'd10:   b = 64'd604800;
                    4'd11:   b = 64'd2592000;
                    default: b = '0;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/saturating_bucket_histogram.sv =====
// top level of the saturating bucket histogram: bucket memory, counters and sequencer
// depends on sbh_pkg and sbh_interval
`default_nettype none

// Bins observed samples into one of three fixed bound tables (duration in ns, byte
// sizes, ttl seconds) picked by cfg_data, with saturating bucket, count, sum, error and
// saturation counters; a read word streams a cumulative snapshot, one result per bucket.
// Bucket counts live in a single-port memory with a registered read, which shapes the
// sequence: an observe passes through the bin and update states, the duration kind first
// waiting on three stages of interval arithmetic ahead of the bucket search, and a
// snapshot requests and emits each bound in turn, holding while m_tready stays low.
// Items are taken one at a time; the next word is accepted while a result waits.
// The bucket store reads as zero after reset, with no clearing pass.
module saturating_bucket_histogram (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_data,   // histogram_kind
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // sample[63:0], start_sec[95:64], start_nsec[125:96], end_sec[157:126],
    // end_nsec[187:158], zero fill
    input  wire logic [sbh_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                             s_tuser,    // func
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // bucket_index[3:0], cumulative[67:4], total_count[131:68], sum_total[195:132],
    // error_count[259:196], saturation_events[323:260], zero fill
    output logic [sbh_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,    // recorded
    output logic                                  m_tlast
);
    import sbh_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_IVWAIT = 3'd1;
    localparam logic [2:0] ST_BIN    = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_RREQ   = 3'd4;
    localparam logic [2:0] ST_RROW   = 3'd5;
    localparam logic [2:0] ST_RLAST  = 3'd6;

    function automatic logic [64:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {1'b1, {64{1'b1}}} : s;
    endfunction

    logic [2:0]             state_reg, state_next;
    logic [1:0]             kind_reg, kind_next;
    logic [63:0]            count_reg, count_next;
    logic [63:0]            sum_reg, sum_next;
    logic [63:0]            err_reg, err_next;
    logic [63:0]            clip_reg, clip_next;
    logic [63:0]            bsamp_reg, bsamp_next;
    logic [63:0]            ssamp_reg, ssamp_next;
    logic                   rej_reg, rej_next;
    logic [BKT_AW-1:0]      bin_reg, bin_next;
    logic [3:0]             row_reg, row_next;
    logic [63:0]            cum_reg, cum_next;
    logic [MAX_BUCKETS-1:0] vld_reg, vld_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic [63:0]            mem [MAX_BUCKETS];
    logic [63:0]            rd_data_reg;
    logic                   rd_vld_reg;

    logic                   mem_re;
    logic                   mem_we;
    logic [BKT_AW-1:0]      mem_ra;
    logic [BKT_AW-1:0]      mem_wa;
    logic [63:0]            mem_wd;

    sbh_iv_t                iv;
    logic                   s_acc;
    logic                   iv_start;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign iv_start  = s_acc && (s_tuser == FUNC_OBSERVE) && (kind_reg == KIND_DUR);

    sbh_interval u_interval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (iv_start),
        .start_sec  (s_tdata[95:64]),
        .start_nsec (s_tdata[125:96]),
        .end_sec    (s_tdata[157:126]),
        .end_nsec   (s_tdata[187:158]),
        .res        (iv)
    );

    always_comb begin
        logic        out_free;
        logic [3:0]  nb;
        logic [3:0]  bkt;
        logic [63:0] bval;
        logic [64:0] s_b;
        logic [64:0] s_c;
        logic [64:0] s_s;
        logic [64:0] s_e;
        logic [64:0] s_k;
        logic [63:0] o_cum;
        logic [3:0]  o_idx;

        state_next    = state_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        err_next      = err_reg;
        clip_next     = clip_reg;
        bsamp_next    = bsamp_reg;
        ssamp_next    = ssamp_reg;
        rej_next      = rej_reg;
        bin_next      = bin_reg;
        row_next      = row_reg;
        cum_next      = cum_reg;
        vld_next      = vld_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_ra        = BKT_AW'(row_reg);
        mem_wa        = bin_reg;
        mem_wd        = '0;

        out_free = !m_tvalid_reg || m_tready;
        nb       = sbh_nbounds(kind_reg);
        bval     = rd_vld_reg ? rd_data_reg : 64'd0;
        s_b      = sat_add64(bval, 64'd1);
        s_c      = sat_add64(count_reg, 64'd1);
        s_s      = sat_add64(sum_reg, ssamp_reg);
        s_e      = sat_add64(err_reg, 64'd1);
        s_k      = sat_add64(clip_reg, 64'd1);
        o_cum    = '0;
        o_idx    = '0;

        bkt = nb;
        for (int i = 12; i >= 0; i--) begin
            if ((4'(i) < nb) && !(bsamp_reg > sbh_bound(kind_reg, 4'(i)))) begin
                bkt = 4'(i);
            end
        end

        if (cfg_valid && cfg_ready) begin
            kind_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    bsamp_next = s_tdata[63:0];
                    ssamp_next = s_tdata[63:0];
                    rej_next   = 1'b0;
                    row_next   = '0;
                    cum_next   = '0;
                    if (s_tuser == FUNC_READ) begin
                        state_next = ST_RREQ;
                    end else if (kind_reg == KIND_DUR) begin
                        state_next = ST_IVWAIT;
                    end else begin
                        state_next = ST_BIN;
                    end
                end
            end
            ST_IVWAIT: begin
                if (iv.valid) begin
                    rej_next   = iv.rej;
                    bsamp_next = iv.bsamp;
                    ssamp_next = iv.ssamp;
                    state_next = iv.rej ? ST_UPD : ST_BIN;
                end
            end
            ST_BIN: begin
                mem_re     = 1'b1;
                mem_ra     = BKT_AW'(bkt);
                bin_next   = BKT_AW'(bkt);
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    if (rej_reg) begin
                        err_next = s_e[63:0];
                        if (s_e[64]) begin
                            clip_next = s_k[63:0];
                        end
                    end else begin
                        mem_we            = 1'b1;
                        mem_wd            = s_b[63:0];
                        vld_next[bin_reg] = 1'b1;
                        count_next        = s_c[63:0];
                        sum_next          = s_s[63:0];
                        if (s_b[64] || s_c[64] || s_s[64]) begin
                            clip_next = s_k[63:0];
                        end
                    end
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = !rej_reg;
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RREQ: begin
                if (row_reg == nb) begin
                    state_next = ST_RLAST;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_RROW;
                end
            end
            ST_RROW: begin
                if (out_free) begin
                    s_s           = sat_add64(cum_reg, bval);
                    o_cum         = s_s[63:0];
                    o_idx         = row_reg;
                    cum_next      = s_s[63:0];
                    row_next      = row_reg + 4'd1;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_RREQ;
                end
            end
            ST_RLAST: begin
                if (out_free) begin
                    o_cum         = count_reg;
                    o_idx         = nb;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (m_tvalid_next && !(m_tvalid_reg && !m_tready)) begin
            m_tdata_next = {4'd0, clip_next, err_next, sum_next, count_next, o_cum, o_idx};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_DUR;
            count_reg    <= '0;
            sum_reg      <= '0;
            err_reg      <= '0;
            clip_reg     <= '0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            err_reg      <= err_next;
            clip_reg     <= clip_next;
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bsamp_reg   <= bsamp_next;
        ssamp_reg   <= ssamp_next;
        rej_reg     <= rej_next;
        bin_reg     <= bin_next;
        row_reg     <= row_next;
        cum_reg     <= cum_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // bucket store, single port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
            rd_vld_reg  <= vld_reg[mem_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/sbh_interval.sv =====
// three-stage interval converter: checks start/end, forms nanoseconds and microseconds
// depends on sbh_pkg
`default_nettype none

module sbh_interval (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [31:0]     start_sec,
    input  wire logic [29:0]     start_nsec,
    input  wire logic [31:0]     end_sec,
    input  wire logic [29:0]     end_nsec,
    output sbh_pkg::sbh_iv_t     res
);
    import sbh_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic        rej1_reg, rej2_reg, rej3_reg;
    logic [31:0] secs1_reg;
    logic [29:0] rem1_reg, rem2_reg;
    logic [61:0] pns2_reg;
    logic [51:0] pus2_reg;
    logic [20:0] q2_reg;
    logic [63:0] bsamp3_reg, ssamp3_reg;

    logic        borrow;
    logic        rej;
    logic [31:0] secs;
    logic [30:0] remw;
    logic [54:0] qprod;

    always_comb begin
        borrow = end_nsec < start_nsec;
        rej    = (start_nsec >= NS_PER_SEC) || (end_nsec >= NS_PER_SEC) ||
                 (end_sec < start_sec) || ((end_sec == start_sec) && borrow);
        secs   = end_sec - start_sec - {31'd0, borrow};
        remw   = {1'b0, end_nsec} + (borrow ? {1'b0, NS_PER_SEC} : 31'd0)
                 - {1'b0, start_nsec};
        qprod  = rem1_reg[29:3] * DIV1000_RECIP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // stage 1: compare and subtract
        rej1_reg  <= rej;
        secs1_reg <= secs;
        rem1_reg  <= remw[29:0];
        // stage 2: constant multiplies
        rej2_reg  <= rej1_reg;
        rem2_reg  <= rem1_reg;
        pns2_reg  <= secs1_reg * NS_PER_SEC;
        pus2_reg  <= secs1_reg * US_PER_SEC;
        q2_reg    <= qprod[54:34];
        // stage 3: final sums
        rej3_reg   <= rej2_reg;
        bsamp3_reg <= {2'b00, pns2_reg} + {34'd0, rem2_reg};
        ssamp3_reg <= {12'd0, pus2_reg} + {43'd0, q2_reg};
    end

    assign res.valid = v3_reg;
    assign res.rej   = rej3_reg;
    assign res.bsamp = bsamp3_reg;
    assign res.ssamp = ssamp3_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for saturating_bucket_histogram: directed and random words on all kinds
// depends on sbh_pkg and the rtl top; a mirror class predicts every result word
`timescale 1ns / 1ps

typedef struct packed {
    logic        func;
    logic [63:0] sample;
    logic [31:0] ss;
    logic [29:0] sn;
    logic [31:0] es;
    logic [29:0] en;
} hist_word_t;

typedef struct packed {
    logic        recorded;
    logic [3:0]  idx;
    logic [63:0] cum;
    logic [63:0] total;
    logic [63:0] sum;
    logic [63:0] err;
    logic [63:0] sat;
    logic        last;
} hist_row_t;

class hist_mirror;
    localparam logic [63:0] NSEC = 64'd1000000000;

    hist_row_t   rows_due[$];
    logic [63:0] bkt[sbh_pkg::MAX_BUCKETS];
    logic [63:0] n_samples;
    logic [63:0] s_sum;
    logic [63:0] n_rejected;
    logic [63:0] n_clipped;
    logic [1:0]  kind;
    logic [63:0] dur_b[13];
    logic [63:0] size_b[9];
    logic [63:0] ttl_b[12];
    int          errors;
    int          words_in;
    int          rows_seen;
    int          reads_seen;
    int          rejects_seen;
    int          clips_seen;

    function new();
        dur_b = '{64'd1000000, 64'd5000000, 64'd10000000, 64'd25000000, 64'd50000000,
                  64'd100000000, 64'd250000000, 64'd500000000, 64'd1000000000,
                  64'd2000000000, 64'd5000000000, 64'd10000000000, 64'd30000000000};
        size_b = '{64'd0, 64'd64, 64'd256, 64'd1024, 64'd4096, 64'd16384, 64'd65536,
                   64'd262144, 64'd1048576};
        ttl_b = '{64'd0, 64'd1, 64'd5, 64'd30, 64'd60, 64'd300, 64'd1800, 64'd3600,
                  64'd21600, 64'd86400, 64'd604800, 64'd2592000};
        foreach (bkt[i]) bkt[i] = '0;
        n_samples = '0;
        s_sum = '0;
        n_rejected = '0;
        n_clipped = '0;
        kind = sbh_pkg::KIND_DUR;
    endfunction

    function void set_kind(logic [1:0] k);
        kind = k;
    endfunction

    function int nbounds(logic [1:0] k);
        int n;
        case (k)
            sbh_pkg::KIND_DUR:  n = 13;
            sbh_pkg::KIND_SIZE: n = 9;
            default:            n = 12;
        endcase
        if (n > sbh_pkg::MAX_BUCKETS - 1) n = sbh_pkg::MAX_BUCKETS - 1;
        return n;
    endfunction

    function logic [63:0] bound(logic [1:0] k, int i);
        case (k)
            sbh_pkg::KIND_DUR:  return dur_b[i];
            sbh_pkg::KIND_SIZE: return size_b[i];
            default:            return ttl_b[i];
        endcase
    endfunction

    // returns 1 when the add clipped
    function bit add_sat(inout logic [63:0] v, input logic [63:0] a);
        if (~v < a) begin
            v = '1;
            return 1'b1;
        end
        v = v + a;
        return 1'b0;
    endfunction

    function void bump_clip();
        clips_seen++;
        if (n_clipped != '1) n_clipped = n_clipped + 1;
    endfunction

    function void push_row(logic rec, logic [3:0] idx, logic [63:0] cum, logic lst);
        hist_row_t r;
        r.recorded = rec;
        r.idx = idx;
        r.cum = cum;
        r.total = n_samples;
        r.sum = s_sum;
        r.err = n_rejected;
        r.sat = n_clipped;
        r.last = lst;
        rows_due.push_back(r);
    endfunction

    function void take_word(hist_word_t w);
        logic [63:0] bs;
        logic [63:0] us;
        logic [63:0] secs;
        logic [63:0] rem;
        logic [63:0] cum;
        int          nb;
        int          b;
        bit          clip;
        words_in++;
        nb = nbounds(kind);
        if (w.func == sbh_pkg::FUNC_READ) begin
            reads_seen++;
            cum = '0;
            for (b = 0; b < nb; b++) begin
                void'(add_sat(cum, bkt[b]));
                push_row(1'b1, 4'(b), cum, 1'b0);
            end
            push_row(1'b1, 4'(nb), n_samples, 1'b1);
            return;
        end
        if (kind == sbh_pkg::KIND_DUR) begin
            if (64'(w.sn) >= NSEC || 64'(w.en) >= NSEC || w.es < w.ss ||
                (w.es == w.ss && w.en < w.sn)) begin
                rejects_seen++;
                if (add_sat(n_rejected, 64'd1)) bump_clip();
                push_row(1'b0, 4'd0, 64'd0, 1'b1);
                return;
            end
            secs = 64'(w.es) - 64'(w.ss);
            if (w.en < w.sn) begin
                secs = secs - 64'd1;
                rem = NSEC + 64'(w.en) - 64'(w.sn);
            end else begin
                rem = 64'(w.en) - 64'(w.sn);
            end
            bs = secs * NSEC + rem;
            us = bs / 64'd1000;
        end else begin
            bs = w.sample;
            us = w.sample;
        end
        b = 0;
        while (b < nb && bs > bound(kind, b)) b++;
        clip = add_sat(bkt[b], 64'd1);
        clip = add_sat(n_samples, 64'd1) | clip;
        clip = add_sat(s_sum, us) | clip;
        if (clip) bump_clip();
        push_row(1'b1, 4'd0, 64'd0, 1'b1);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, e, a);
        end
    endfunction

    function void check_row(logic rec, logic [sbh_pkg::OUT_DATA_W-1:0] d, logic lst);
        hist_row_t e;
        rows_seen++;
        if (rows_due.size() == 0) begin
            errors++;
            $display("%0t unexpected result word: expected none, actual bucket_index %0d",
                     $time, d[3:0]);
            return;
        end
        e = rows_due.pop_front();
        cmp("recorded", 64'(e.recorded), 64'(rec));
        cmp("bucket_index", 64'(e.idx), 64'(d[3:0]));
        cmp("cumulative", e.cum, d[67:4]);
        cmp("total_count", e.total, d[131:68]);
        cmp("sum_total", e.sum, d[195:132]);
        cmp("error_count", e.err, d[259:196]);
        cmp("saturation_events", e.sat, d[323:260]);
        cmp("last", 64'(e.last), 64'(lst));
    endfunction

    function int pending();
        return rows_due.size();
    endfunction
endclass

module tb_top;
    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [1:0]                     cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sbh_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sbh_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    hist_mirror mirror = new();
    bit         quiet;

    saturating_bucket_histogram i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic hist_word_t dur_word(logic [31:0] ss, logic [29:0] sn,
                                            logic [31:0] es, logic [29:0] en);
        hist_word_t w;
        w.func = sbh_pkg::FUNC_OBSERVE;
        w.sample = {$urandom, $urandom};
        w.ss = ss;
        w.sn = sn;
        w.es = es;
        w.en = en;
        return w;
    endfunction

    function automatic hist_word_t val_word(logic [63:0] v);
        hist_word_t w;
        w = dur_word($urandom, 30'($urandom), $urandom, 30'($urandom));
        w.sample = v;
        return w;
    endfunction

    function automatic hist_word_t read_word();
        hist_word_t w;
        w = val_word({$urandom, $urandom});
        w.func = sbh_pkg::FUNC_READ;
        return w;
    endfunction

    // mostly well-formed intervals, some noise and some reversed ones
    function automatic hist_word_t pick_interval();
        hist_word_t  w;
        int          r;
        int unsigned d;
        logic [31:0] dsec;
        w = dur_word($urandom, 30'($urandom), $urandom, 30'($urandom));
        r = $urandom_range(0, 99);
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: dsec = 32'd0;
                1: dsec = $urandom_range(1, 3);
                2: dsec = $urandom_range(4, 40);
                default: dsec = $urandom;
            endcase
            if (w.ss > 32'hFFFFFFFF - dsec) w.ss = 32'hFFFFFFFF - dsec;
            w.es = w.ss + dsec;
            w.sn = 30'($urandom_range(0, 999999999));
            w.en = 30'($urandom_range(0, 999999999));
            if (dsec == 0) begin
                d = $urandom_range(0, 60000000);
                w.sn = 30'($urandom_range(0, 999999999 - d));
                w.en = w.sn + 30'(d);
            end
        end else if (r >= 85) begin
            if ($urandom_range(0, 1) == 0) begin
                w.ss = $urandom_range(1, 32'hFFFFFFFF);
                w.es = $urandom_range(0, w.ss - 1);
            end else begin
                w.es = w.ss;
                w.sn = 30'($urandom_range(1, 999999999));
                w.en = 30'($urandom_range(0, w.sn - 1));
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] pick_sample(logic [1:0] k, bit huge);
        int          r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (huge && r < 50) begin
            v = {$urandom, $urandom};
        end else if (r < 55) begin
            v = mirror.bound(k, $urandom_range(0, mirror.nbounds(k) - 1));
            case ($urandom_range(0, 2))
                0: if (v != 0) v = v - 1;
                2: v = v + 1;
                default: ;
            endcase
        end else if (r < 90) begin
            v = 64'($urandom_range(0, 3000000));
        end else begin
            v = 64'($urandom);
        end
        return v;
    endfunction

    task automatic send_word(input hist_word_t w);
        int g;
        g = quiet ? 0 : gap_len();
        @(negedge aclk);
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata = {4'b0, w.en, w.es, w.sn, w.ss, w.sample};
        s_tuser = w.func;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        mirror.take_word(w);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mirror.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_kind(input logic [1:0] k);
        wait_drained();
        repeat (8) @(negedge aclk);
        cfg_data = k;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        mirror.set_kind(k);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0 && !quiet) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) mirror.check_row(m_tuser, m_tdata, m_tlast);
    end

    initial begin
        int          p;
        int          i;
        logic [1:0]  k;
        hist_word_t  w;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        quiet = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_kind(sbh_pkg::KIND_DUR);
        send_word(read_word());
        send_word(dur_word(32'd7, 30'd0, 32'd7, 30'd0));
        send_word(dur_word(32'd5, 30'd0, 32'd5, 30'd1000000));
        send_word(dur_word(32'd5, 30'd0, 32'd5, 30'd1000001));
        send_word(dur_word(32'd10, 30'd999999999, 32'd11, 30'd0));
        send_word(dur_word(32'd20, 30'd0, 32'd50, 30'd0));
        send_word(dur_word(32'd3, 30'd1000000000, 32'd4, 30'd0));
        send_word(dur_word(32'd3, 30'd0, 32'd4, 30'h3FFFFFFF));
        send_word(dur_word(32'd100, 30'd0, 32'd99, 30'd0));
        send_word(dur_word(32'd50, 30'd500, 32'd50, 30'd499));
        send_word(dur_word(32'd0, 30'd0, 32'hFFFFFFFF, 30'd999999999));
        send_word(read_word());

        write_kind(sbh_pkg::KIND_SIZE);
        send_word(val_word(64'd0));
        send_word(val_word(64'd64));
        send_word(val_word(64'd65));
        send_word(val_word(64'd1048576));
        send_word(val_word(64'd1048577));
        send_word(read_word());

        write_kind(sbh_pkg::KIND_TTL);
        send_word(val_word(64'd0));
        send_word(val_word(64'd1));
        send_word(val_word(64'd2592000));
        send_word(val_word(64'd2592001));
        send_word(read_word());

        write_kind(2'd3);
        send_word(val_word(64'd2));
        send_word(read_word());

        // random phases; the last one may push the sum into saturation
        for (p = 0; p < 6; p++) begin
            k = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
            write_kind(k);
            quiet = (p == 2);
            for (i = 0; i < 16; i++) begin
                if (p == 1 && i == 10) wait_drained();
                if ($urandom_range(0, 7) == 0) w = read_word();
                else if (k == sbh_pkg::KIND_DUR) w = pick_interval();
                else w = val_word(pick_sample(k, p == 5));
                send_word(w);
            end
            if (p == 5) send_word(read_word());
        end
        quiet = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("run covered %0d input words and %0d result words, %0d of them snapshots",
                 mirror.words_in, mirror.rows_seen, mirror.reads_seen);
        $display("all four kind settings used, %0d rejected intervals, %0d clipped observes",
                 mirror.rejects_seen, mirror.clips_seen);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
